@@ src/utf8_atomizer_byte_fallback_unit_assert.svh @@
// ----------------------------------------------------------------------------
// UTF-8 atomizer assertion macros
// Shared assertion shorthands, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_ATOMIZER_BYTE_FALLBACK_UNIT_ASSERT_SVH
`define UTF8_ATOMIZER_BYTE_FALLBACK_UNIT_ASSERT_SVH

// Property holds at every clock edge out of reset.
`define UTF8AB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define UTF8AB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/utf8ab_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 atomizer package
// Types, byte range constants and lead/continuation checks.
// ----------------------------------------------------------------------------
package utf8ab_pkg;

  localparam int unsigned AtomW    = 21;
  localparam int unsigned MaxRes   = 4;
  localparam int unsigned MaxHeld  = 3;

  localparam logic [7:0] AsciiTop   = 8'h80;
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead2Max   = 8'hDF;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead3Max   = 8'hEF;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] Lead4Max   = 8'hF4;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] ContMin    = 8'h80;
  localparam logic [7:0] ContMax    = 8'hBF;
  localparam logic [7:0] ContE0Min  = 8'hA0;
  localparam logic [7:0] ContEDMax  = 8'h9F;
  localparam logic [7:0] ContF0Min  = 8'h90;
  localparam logic [7:0] ContF4Max  = 8'h8F;

  typedef struct packed {
    logic [AtomW-1:0] atom;
    logic             from_seq;
  } atom_t;

  typedef struct packed {
    logic [MaxHeld-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic [2:0]              seq_len;
  } pend_t;

  typedef struct packed {
    atom_t [MaxRes-1:0] res;
    logic  [2:0]        nres;
  } step_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= Lead2Min && b <= Lead2Max) len = 3'd2;
    if (b >= Lead3Min && b <= Lead3Max) len = 3'd3;
    if (b >= Lead4Min && b <= Lead4Max) len = 3'd4;
    return len;
  endfunction

  // first: the byte right after the lead, where the tighter ranges apply
  function automatic logic cont_ok(input logic [7:0] lead, input logic first,
                                   input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = ContMin;
    hi = ContMax;
    if (first) begin
      if (lead == LeadE0) lo = ContE0Min;
      if (lead == LeadED) hi = ContEDMax;
      if (lead == LeadF0) lo = ContF0Min;
      if (lead == LeadF4) hi = ContF4Max;
    end
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

@@ src/utf8ab_step.sv @@
// ----------------------------------------------------------------------------
// UTF-8 atomizer step
// Resolves held prefix plus one new byte into up to four atoms.
// ----------------------------------------------------------------------------
module utf8ab_step
  import utf8ab_pkg::*;
(
  input  logic       byte_mode_i,
  input  pend_t      pend_i,
  input  logic [7:0] text_byte_i,
  input  logic       eot_i,
  output step_t      step_o,
  output pend_t      pend_o
);

  logic             emit_held;
  logic             emit_nb;
  logic             emit_cp;
  logic             nb_pends;
  logic             ok;
  logic [AtomW-1:0] cp;

  // A lone byte pends only if it is a valid lead and more bytes may follow
  assign nb_pends = (text_byte_i >= AsciiTop) && (lead_length(text_byte_i) != 3'd0) &&
                    !eot_i;
  assign ok       = cont_ok(pend_i.bytes[0], pend_i.cnt == 2'd1, text_byte_i);

  always_comb begin
    unique case (pend_i.seq_len)
      3'd2:    cp = {10'd0, pend_i.bytes[0][4:0], text_byte_i[5:0]};
      3'd3:    cp = {5'd0, pend_i.bytes[0][3:0], pend_i.bytes[1][5:0], text_byte_i[5:0]};
      default: cp = {pend_i.bytes[0][2:0], pend_i.bytes[1][5:0], pend_i.bytes[2][5:0],
                     text_byte_i[5:0]};
    endcase
  end

  always_comb begin
    emit_held = 1'b0;
    emit_nb   = 1'b0;
    emit_cp   = 1'b0;
    pend_o    = pend_i;
    pend_o.cnt     = 2'd0;
    pend_o.seq_len = 3'd0;
    if (byte_mode_i) begin
      emit_held = 1'b1;
      emit_nb   = 1'b1;
    end else if (pend_i.cnt == 2'd0 || !ok) begin
      emit_held = (pend_i.cnt != 2'd0);
      if (nb_pends) begin
        pend_o.bytes[0] = text_byte_i;
        pend_o.cnt      = 2'd1;
        pend_o.seq_len  = lead_length(text_byte_i);
      end else begin
        emit_nb = 1'b1;
      end
    end else if ({1'b0, pend_i.cnt} + 3'd1 == pend_i.seq_len) begin
      emit_cp = 1'b1;
    end else if (eot_i) begin
      emit_held = 1'b1;
      emit_nb   = 1'b1;
    end else begin
      for (int k = 0; k < MaxHeld; k++) begin
        if (pend_i.cnt == k[1:0]) pend_o.bytes[k] = text_byte_i;
      end
      pend_o.cnt     = pend_i.cnt + 2'd1;
      pend_o.seq_len = pend_i.seq_len;
    end
  end

  always_comb begin
    for (int k = 0; k < MaxHeld; k++) begin
      step_o.res[k].from_seq = 1'b0;
      if (k[1:0] < pend_i.cnt) begin
        step_o.res[k].atom = {13'd0, pend_i.bytes[k]};
      end else begin
        step_o.res[k].atom = {13'd0, text_byte_i};
      end
    end
    step_o.res[MaxRes-1].atom     = {13'd0, text_byte_i};
    step_o.res[MaxRes-1].from_seq = 1'b0;
    if (emit_cp) begin
      step_o.res[0].atom     = cp;
      step_o.res[0].from_seq = 1'b1;
      step_o.nres            = 3'd1;
    end else begin
      step_o.nres = (emit_held ? {1'b0, pend_i.cnt} : 3'd0) + {2'd0, emit_nb};
    end
  end

endmodule

@@ src/utf8_atomizer_byte_fallback_unit.sv @@
// ----------------------------------------------------------------------------
// UTF-8 atomizer with byte fallback
// Decodes a byte stream into code points, falling back to raw bytes.
// ----------------------------------------------------------------------------
// Input stream: one text byte per transfer on s_axis_tdata, s_axis_tlast marks
// the last byte of a text and flushes any held sequence bytes.
// Output stream: one atom per transfer; tuser set for a decoded multi-byte
// sequence, tlast set on the final atom caused by an input byte.
// cfg_we_i/cfg_wdata_i write the byte mode bit (1: every byte passes raw);
// write it only while the block is idle.
// Latency: the first atom of a byte appears the cycle after the byte is taken.
// Throughput: one byte per cycle while the receiver is ready and each byte
// yields at most one atom. A byte yielding k atoms (k up to 4) occupies the
// 4-entry result buffer, which drains one atom per cycle; the next byte
// enters as the last atom leaves. A byte only extending a prefix yields none.
// Reset clears the held bytes, the result buffer and selects decode mode.
// When the receiver stalls, the buffer holds and input stalls once the
// buffer cannot be emptied in the current cycle.
// ----------------------------------------------------------------------------
`include "utf8_atomizer_byte_fallback_unit_assert.svh"

module utf8_atomizer_byte_fallback_unit
  import utf8ab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // byte_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] atom, [23:21] zero
  output logic        m_axis_tuser,   // [0] from_sequence
  output logic        m_axis_tlast
);

  logic               byte_mode_q;
  pend_t              pend_q, pend_d;
  step_t              step;
  atom_t [MaxRes-1:0] res_q;
  logic  [2:0]        res_cnt_q, res_cnt_d;
  logic  [1:0]        rd_idx_q, rd_idx_d;
  logic               in_fire;
  logic               out_fire;

  utf8ab_step u_step (
    .byte_mode_i (byte_mode_q),
    .pend_i      (pend_q),
    .text_byte_i (s_axis_tdata),
    .eot_i       (s_axis_tlast),
    .step_o      (step),
    .pend_o      (pend_d)
  );

  assign m_axis_tvalid = (res_cnt_q != 3'd0);
  assign s_axis_tready = (res_cnt_q == 3'd0) || (res_cnt_q == 3'd1 && m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign m_axis_tdata  = {3'd0, res_q[rd_idx_q].atom};
  assign m_axis_tuser  = res_q[rd_idx_q].from_seq;
  assign m_axis_tlast  = (res_cnt_q == 3'd1);

  always_comb begin
    res_cnt_d = res_cnt_q;
    rd_idx_d  = rd_idx_q;
    if (in_fire) begin
      res_cnt_d = step.nres;
      rd_idx_d  = 2'd0;
    end else if (out_fire) begin
      res_cnt_d = res_cnt_q - 3'd1;
      rd_idx_d  = rd_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_mode_q <= 1'b0;
      pend_q      <= '0;
      res_cnt_q   <= 3'd0;
      rd_idx_q    <= 2'd0;
    end else begin
      if (cfg_we_i) byte_mode_q <= cfg_wdata_i;
      if (in_fire) pend_q <= pend_d;
      res_cnt_q <= res_cnt_d;
      rd_idx_q  <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= step.res;
    end
  end

  `UTF8AB_ASSERT(a_res_cnt_range, res_cnt_q <= 3'd4, "result count above buffer depth")
  `UTF8AB_ASSERT(a_pend_shorter, (pend_q.cnt == 2'd0) || (pend_q.seq_len > {1'b0, pend_q.cnt}),
    "held prefix not shorter than its sequence")
  `UTF8AB_ASSERT(a_pend_empty_len, (pend_q.cnt != 2'd0) || (pend_q.seq_len == 3'd0),
    "sequence length set with nothing held")
  `UTF8AB_ASSERT(a_ready_drain, !(s_axis_tready && m_axis_tvalid) ||
    (res_cnt_q == 3'd1 && m_axis_tready), "input taken while buffer not draining")
  `UTF8AB_ASSERT_NEXT(a_load_valid, in_fire && (step.nres != 3'd0),
    m_axis_tvalid && (rd_idx_q == 2'd0), "loaded results not presented")

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// UTF-8 atomizer with byte fallback: testbench
// Streams text bytes into the atomizer with random gaps on both sides. Each
// accepted byte runs through a local decoder that predicts the atoms it
// causes. Every output transfer is checked field by field against the oldest
// predicted atom. Decode mode is covered with directed edge cases, then
// random text: mostly well-formed UTF-8, plus noise and broken sequences.
// Byte mode is covered too, including a mode change while bytes are held,
// and a long receiver hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import utf8ab_pkg::*;

  localparam int unsigned ResetCycles = 9;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned StuckLimit  = 1000;

  typedef struct packed {
    logic [AtomW-1:0] cp;
    logic             seq;
    logic             last;
  } atom_rec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  atom_rec_t   due_atoms[$];
  logic [7:0]  held_bytes[MaxHeld];
  int unsigned held_cnt;
  logic        raw_mode;
  int unsigned n_errors;
  int unsigned stuck_cycles;
  bit          tx_gaps_on;
  bit          rx_stalls_on;
  bit          hold_off_req;

  utf8_atomizer_byte_fallback_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------- decoder

  function automatic int unsigned seq_bytes(input logic [7:0] lead);
    if (lead inside {[Lead2Min:Lead2Max]}) return 2;
    if (lead inside {[Lead3Min:Lead3Max]}) return 3;
    if (lead inside {[Lead4Min:Lead4Max]}) return 4;
    return 0;
  endfunction

  function automatic bit cont_fits(input logic [7:0] lead, input int unsigned pos,
                                   input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = ContMin;
    hi = ContMax;
    if (pos == 1) begin
      case (lead)
        LeadE0: lo = ContE0Min;
        LeadED: hi = ContEDMax;
        LeadF0: lo = ContF0Min;
        LeadF4: hi = ContF4Max;
        default: ;
      endcase
    end
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic atom_rec_t raw_atom(input logic [7:0] b);
    atom_rec_t rec;
    rec.cp   = {{(AtomW-8){1'b0}}, b};
    rec.seq  = 1'b0;
    rec.last = 1'b0;
    return rec;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic [7:0]  win[4];
    atom_rec_t   step_q[$];
    atom_rec_t   rec;
    int unsigned n;
    int unsigned i;
    int unsigned len;
    int unsigned lim;
    bit          bad;
    n = 0;
    for (int unsigned k = 0; k < held_cnt; k++) begin
      win[n] = held_bytes[k];
      n++;
    end
    win[n] = b;
    n++;
    i = 0;
    if (raw_mode) begin
      for (int unsigned k = 0; k < n; k++) step_q = {step_q, raw_atom(win[k])};
      i = n;
    end else begin
      while (i < n) begin
        len = seq_bytes(win[i]);
        lim = (n - i < len) ? n - i : len;
        bad = 1'b0;
        for (int unsigned k = 1; k < lim; k++) begin
          if (!cont_fits(win[i], k, win[i+k])) bad = 1'b1;
        end
        if (len == 0 || bad) begin
          step_q = {step_q, raw_atom(win[i])};
          i++;
        end else if (n - i >= len) begin
          case (len)
            2: rec.cp = AtomW'({win[i][4:0], win[i+1][5:0]});
            3: rec.cp = AtomW'({win[i][3:0], win[i+1][5:0], win[i+2][5:0]});
            default: rec.cp = {win[i][2:0], win[i+1][5:0], win[i+2][5:0], win[i+3][5:0]};
          endcase
          rec.seq  = 1'b1;
          rec.last = 1'b0;
          step_q = {step_q, rec};
          i += len;
        end else if (eot) begin
          step_q = {step_q, raw_atom(win[i])};
          i++;
        end else begin
          break;
        end
      end
    end
    held_cnt = 0;
    for (int unsigned k = i; k < n && held_cnt < MaxHeld; k++) begin
      held_bytes[held_cnt] = win[k];
      held_cnt++;
    end
    for (int k = 0; k < step_q.size(); k++) begin
      rec      = step_q[k];
      rec.last = (k == step_q.size() - 1);
      due_atoms = {due_atoms, rec};
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int unsigned pick_gap(input bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int unsigned gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(b, eot);
  endtask

  // nothing in flight: only then may the mode register change
  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (due_atoms.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_byte_mode(input logic m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    raw_mode = m;
  endtask

  function automatic logic [AtomW-1:0] pick_code_point(input int unsigned nb);
    logic [AtomW-1:0] cp;
    case (nb)
      1: cp = AtomW'($urandom_range(0, 'h7F));
      2: cp = AtomW'($urandom_range('h80, 'h7FF));
      3: begin
        cp = AtomW'($urandom_range('h800, 'hFFFF));
        if (cp inside {['hD800:'hDFFF]}) cp = cp ^ AtomW'('h8000);
      end
      default: cp = AtomW'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // keep == 0 sends the whole encoding, else only its first keep bytes
  task automatic send_char(input logic [AtomW-1:0] cp, input int unsigned keep,
                           input logic eot_last, output int unsigned cnt);
    logic [7:0]  enc[4];
    int unsigned len;
    if (cp < 'h80) begin
      len = 1;
      enc[0] = cp[7:0];
    end else if (cp < 'h800) begin
      len = 2;
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
    end else if (cp < 'h10000) begin
      len = 3;
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
    end else begin
      len = 4;
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
    end
    cnt = (keep == 0 || keep > len) ? len : keep;
    for (int unsigned k = 0; k < cnt; k++) send_byte(enc[k], eot_last && (k == cnt - 1));
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : rx_side
    int unsigned stall_left;
    int unsigned hold_left;
    m_axis_tready <= 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(rx_stalls_on);
      end
    end
  end

  always @(posedge clk_i) begin : check_atoms
    atom_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_atoms.size() == 0) begin
        $error("atom: none expected, got %h", m_axis_tdata[AtomW-1:0]);
        n_errors++;
      end else begin
        want = due_atoms.pop_front();
        if (m_axis_tdata[AtomW-1:0] !== want.cp) begin
          $error("atom: expected %h, got %h", want.cp, m_axis_tdata[AtomW-1:0]);
          n_errors++;
        end
        if (m_axis_tuser !== want.seq) begin
          $error("from_sequence: expected %b, got %b", want.seq, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_decode_directed();
    logic [8:0] plan[$];
    // bit 8 is end of text
    plan = '{9'h000, 9'h07F,                  // ASCII extremes
             9'h0C2, 9'h080, 9'h0DF, 9'h0BF,  // U+0080, U+07FF
             9'h0E0, 9'h0A0, 9'h080,          // U+0800
             9'h0ED, 9'h0A0,                  // surrogate, early fallback
             9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,  // U+10FFFF
             9'h0F0, 9'h08F,                  // overlong four-byte form
             9'h0C0, 9'h0FF,                  // invalid leads
             9'h0E2, 9'h182,                  // cut off at end of text
             9'h0F0, 9'h090, 9'h080, 9'h041}; // three held then fail: four atoms
    foreach (plan[k]) send_byte(plan[k][7:0], plan[k][8]);
    drain_all();
  endtask

  // held prefix survives the mode change, then leaves raw ahead of the new byte
  task automatic test_mode_switch();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    drain_all();
    set_byte_mode(1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_all();
    set_byte_mode(1'b0);
  endtask

  task automatic run_decode_mix(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned nb;
    int unsigned r;
    int unsigned cnt;
    logic        cut_by_eot;
    sent = 0;
    while (sent < n_bytes) begin
      r  = $urandom_range(0, 99);
      nb = $urandom_range(1, 4);
      if (r < 70) begin
        send_char(pick_code_point(nb), 0, $urandom_range(0, 9) == 0, cnt);
      end else if (r < 85 && nb > 1) begin
        cut_by_eot = ($urandom_range(0, 1) == 1);
        send_char(pick_code_point(nb), $urandom_range(1, nb - 1), cut_by_eot, cnt);
        if (!cut_by_eot) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          cnt++;
        end
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        cnt = 1;
      end
      sent += cnt;
    end
  endtask

  task automatic test_decode_random();
    run_decode_mix(55);
    drain_all();
  endtask

  task automatic test_byte_random();
    set_byte_mode(1'b1);
    repeat (25) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    drain_all();
    set_byte_mode(1'b0);
  endtask

  task automatic test_back_to_back();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    run_decode_mix(25);
    drain_all();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // fallback bursts against a receiver that holds off: input must stall
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    hold_off_req = 1'b1;
    repeat (6) begin
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h41, 1'b0);
    end
    drain_all();
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    raw_mode      = 1'b0;
    held_cnt      = 0;
    n_errors      = 0;
    stuck_cycles  = 0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    hold_off_req  = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_decode_directed();
    test_mode_switch();
    test_decode_random();
    test_byte_random();
    test_back_to_back();
    test_backpressure();

    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
